>>> hdl/mt64_pkg.sv
package mt64_pkg;

   localparam int STATE_DEPTH_DEF  = 312;
   localparam int TWIST_OFFSET_DEF = 156;
   localparam int KEY_DEPTH_DEF    = 16;

   localparam logic [1:0] OP_SEED_WORD = 2'd0;
   localparam logic [1:0] OP_LOAD_KEY  = 2'd1;
   localparam logic [1:0] OP_SEED_KEYS = 2'd2;
   localparam logic [1:0] OP_DRAW      = 2'd3;

   localparam logic [63:0] SEED_MULT    = 64'd6364136223846793005;
   localparam logic [63:0] MIX_MULT_A   = 64'd3935559000370003845;
   localparam logic [63:0] MIX_MULT_B   = 64'd2862933555777941757;
   localparam logic [63:0] KEY_BASE     = 64'd19650218;
   localparam logic [63:0] DEFAULT_SEED = 64'd5489;
   localparam logic [63:0] TWIST_MATRIX = 64'hB502_6F5A_A966_19E9;
   localparam logic [63:0] HIGH_MASK    = 64'hFFFF_FFFF_8000_0000;
   localparam logic [63:0] LOW_MASK     = 64'h0000_0000_7FFF_FFFF;
   localparam logic [63:0] TOP_BIT      = 64'h8000_0000_0000_0000;
   localparam logic [63:0] TEMPER_U     = 64'h5555_5555_5555_5555;
   localparam logic [63:0] TEMPER_B     = 64'h71D6_7FFF_EDA6_0000;
   localparam logic [63:0] TEMPER_C     = 64'hFFF7_EEE0_0000_0000;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEED_FIRST,
      ST_SEED_MUL,
      ST_MIX_START,
      ST_MIX_WAIT,
      ST_MIX_WRAP,
      ST_MIX_FINAL,
      ST_TW_PRIME,
      ST_TW_A,
      ST_TW_B,
      ST_TW_C,
      ST_DRAW_OUT
   } eng_state_type;

   typedef enum logic [1:0] {
      PLAN_NONE,
      PLAN_KEYS,
      PLAN_DRAW
   } plan_type;

   typedef struct packed {
      logic [1:0]  operation;
      logic [63:0] data_word;
      logic [3:0]  key_slot;
      logic [4:0]  key_count;
   } cmd_type;

   typedef struct packed {
      logic        start;
      logic [63:0] operand;
      logic [63:0] factor;
   } mul_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] product;
   } mul_rsp_type;

   function automatic logic [63:0] fold62(input logic [63:0] p);
      return p ^ (p >> 62);
   endfunction

   function automatic logic [63:0] temper(input logic [63:0] raw);
      logic [63:0] v;
      v = raw;
      v = v ^ ((v >> 29) & TEMPER_U);
      v = v ^ ((v << 17) & TEMPER_B);
      v = v ^ ((v << 37) & TEMPER_C);
      v = v ^ (v >> 43);
      return v;
   endfunction

endpackage

>>> hdl/mt64_mul.sv
module mt64_mul
   import mt64_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  mul_req_type req,
   output mul_rsp_type rsp
);

   // low 64 bits of a 64x64 product, one 32x32 partial product per cycle
   logic [1:0]  phase_ff, phase_in;
   logic        done_ff, done_in;
   logic [63:0] x_ff, x_in;
   logic [63:0] c_ff, c_in;
   logic [63:0] acc_ff, acc_in;
   logic [31:0] mul_a, mul_b;
   logic [63:0] part;

   assign mul_a = (phase_ff == 2'd3) ? x_ff[63:32] : x_ff[31:0];
   assign mul_b = (phase_ff == 2'd2) ? c_ff[63:32] : c_ff[31:0];
   assign part  = mul_a * mul_b;

   always_comb begin
      phase_in = phase_ff;
      done_in  = 1'b0;
      x_in     = x_ff;
      c_in     = c_ff;
      acc_in   = acc_ff;
      case (phase_ff)
         2'd1: begin
            acc_in   = part;
            phase_in = 2'd2;
         end
         2'd2: begin
            acc_in   = acc_ff + {part[31:0], 32'h0};
            phase_in = 2'd3;
         end
         2'd3: begin
            acc_in   = acc_ff + {part[31:0], 32'h0};
            phase_in = 2'd0;
            done_in  = 1'b1;
         end
         default: begin
         end
      endcase
      if (req.start) begin
         x_in     = req.operand;
         c_in     = req.factor;
         phase_in = 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 2'd0;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
      x_ff   <= x_in;
      c_ff   <= c_in;
      acc_ff <= acc_in;
   end

   assign rsp.done    = done_ff;
   assign rsp.product = acc_ff;

endmodule

>>> hdl/mt64_engine.sv
module mt64_engine
   import mt64_pkg::*;
#(
   parameter int STATE_DEPTH  = STATE_DEPTH_DEF,
   parameter int TWIST_OFFSET = TWIST_OFFSET_DEF,
   parameter int KEY_DEPTH    = KEY_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   input  logic        cmd_valid,
   output logic        cmd_ready,
   input  logic        out_free,
   output logic        raw_valid,
   output logic [63:0] raw_word
);

   localparam int AW = $clog2(STATE_DEPTH);
   localparam int PW = $clog2(STATE_DEPTH + 2);
   localparam int KW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
   localparam logic [PW-1:0] POS_EXHAUSTED = PW'(STATE_DEPTH);
   localparam logic [PW-1:0] POS_UNSEEDED  = PW'(STATE_DEPTH + 1);
   localparam logic [PW-1:0] PASS_ONE      = PW'(STATE_DEPTH);
   localparam logic [PW-1:0] PASS_TWO      = PW'(STATE_DEPTH - 1);
   localparam logic [AW-1:0] LAST_ADDR     = AW'(STATE_DEPTH - 1);
   localparam logic [AW-1:0] OFFSET        = AW'(TWIST_OFFSET);
   localparam logic [AW-1:0] SPAN          = AW'(STATE_DEPTH - TWIST_OFFSET);

   logic [63:0] state_mem [STATE_DEPTH];
   logic [63:0] key_mem [KEY_DEPTH];

   eng_state_type state_ff, state_in;
   plan_type      plan_ff, plan_in;
   logic          second_ff, second_in;
   logic [PW-1:0] pos_ff, pos_in;
   logic [PW-1:0] k_ff, k_in;
   logic [AW-1:0] n_ff, n_in;
   logic [4:0]    j_ff, j_in;
   logic [4:0]    len_ff, len_in;
   logic [63:0]   p_ff, p_in;
   logic [63:0]   cur_ff, cur_in;
   logic [63:0]   nxt_ff, nxt_in;
   logic [63:0]   seed_ff, seed_in;

   logic          s_we, s_re, key_we, key_re;
   logic [AW-1:0] s_waddr, s_raddr;
   logic [63:0]   s_wdata, s_rd_ff, key_rd_ff;
   logic [KW-1:0] key_waddr, key_raddr;

   mul_req_type mreq;
   mul_rsp_type mrsp;

   logic [63:0]   seed_val, mix_val, twist_y, twist_val;
   logic [AW-1:0] next_addr, far_addr;
   logic [4:0]    j_step, len_clamp;
   logic          slot_ok;

   mt64_mul u_mul (
      .clock (clock),
      .reset (reset),
      .req   (mreq),
      .rsp   (mrsp)
   );

   assign seed_val  = mrsp.product + 64'(n_ff);
   assign mix_val   = second_ff ? ((s_rd_ff ^ mrsp.product) - 64'(n_ff))
                                : ((s_rd_ff ^ mrsp.product) + key_rd_ff + 64'(j_ff));
   assign twist_y   = (cur_ff & HIGH_MASK) | (nxt_ff & LOW_MASK);
   assign twist_val = s_rd_ff ^ (twist_y >> 1) ^ (twist_y[0] ? TWIST_MATRIX : 64'h0);
   assign next_addr = (n_ff == LAST_ADDR) ? '0 : n_ff + 1'b1;
   assign far_addr  = (n_ff < SPAN) ? n_ff + OFFSET : n_ff - SPAN;
   assign j_step    = (j_ff + 5'd1 == len_ff) ? 5'd0 : j_ff + 5'd1;
   assign slot_ok   = 32'(cmd.key_slot) < KEY_DEPTH;
   assign key_raddr = KW'(j_ff);
   assign key_waddr = KW'(cmd.key_slot);

   always_comb begin
      if (cmd.key_count == 5'd0) begin
         len_clamp = 5'd1;
      end else if (32'(cmd.key_count) > KEY_DEPTH) begin
         len_clamp = 5'(KEY_DEPTH);
      end else begin
         len_clamp = cmd.key_count;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               case (cmd.operation)
                  OP_SEED_WORD, OP_SEED_KEYS: state_in = ST_SEED_FIRST;
                  OP_DRAW: begin
                     if (pos_ff == POS_UNSEEDED) begin
                        state_in = ST_SEED_FIRST;
                     end else if (pos_ff == POS_EXHAUSTED) begin
                        state_in = ST_TW_PRIME;
                     end else begin
                        state_in = ST_DRAW_OUT;
                     end
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_SEED_FIRST: state_in = ST_SEED_MUL;
         ST_SEED_MUL: begin
            if (mrsp.done && n_ff == LAST_ADDR) begin
               case (plan_ff)
                  PLAN_KEYS: state_in = ST_MIX_START;
                  PLAN_DRAW: state_in = ST_TW_PRIME;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_MIX_START: state_in = ST_MIX_WAIT;
         ST_MIX_WAIT: begin
            if (mrsp.done) begin
               if (n_ff == LAST_ADDR) begin
                  state_in = ST_MIX_WRAP;
               end else if (k_ff == PW'(1) && second_ff) begin
                  state_in = ST_MIX_FINAL;
               end else begin
                  state_in = ST_MIX_START;
               end
            end
         end
         ST_MIX_WRAP: begin
            state_in = (k_ff == '0 && second_ff) ? ST_MIX_FINAL : ST_MIX_START;
         end
         ST_MIX_FINAL: state_in = ST_IDLE;
         ST_TW_PRIME:  state_in = ST_TW_A;
         ST_TW_A:      state_in = ST_TW_B;
         ST_TW_B:      state_in = ST_TW_C;
         ST_TW_C:      state_in = (n_ff == LAST_ADDR) ? ST_DRAW_OUT : ST_TW_A;
         ST_DRAW_OUT:  state_in = out_free ? ST_IDLE : ST_DRAW_OUT;
         default:      state_in = ST_IDLE;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      plan_in      = plan_ff;
      second_in    = second_ff;
      pos_in       = pos_ff;
      k_in         = k_ff;
      n_in         = n_ff;
      j_in         = j_ff;
      len_in       = len_ff;
      p_in         = p_ff;
      cur_in       = cur_ff;
      nxt_in       = nxt_ff;
      seed_in      = seed_ff;
      s_we         = 1'b0;
      s_waddr      = n_ff;
      s_wdata      = mix_val;
      s_re         = 1'b0;
      s_raddr      = n_ff;
      key_we       = 1'b0;
      key_re       = 1'b0;
      mreq.start   = 1'b0;
      mreq.operand = fold62(p_ff);
      mreq.factor  = second_ff ? MIX_MULT_B : MIX_MULT_A;
      cmd_ready    = 1'b0;
      raw_valid    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            cmd_ready = 1'b1;
            if (cmd_valid) begin
               case (cmd.operation)
                  OP_SEED_WORD: begin
                     seed_in = cmd.data_word;
                     plan_in = PLAN_NONE;
                  end
                  OP_LOAD_KEY: key_we = slot_ok;
                  OP_SEED_KEYS: begin
                     seed_in = KEY_BASE;
                     plan_in = PLAN_KEYS;
                     len_in  = len_clamp;
                  end
                  default: begin
                     if (pos_ff == POS_UNSEEDED) begin
                        seed_in = DEFAULT_SEED;
                        plan_in = PLAN_DRAW;
                     end else if (pos_ff != POS_EXHAUSTED) begin
                        s_re    = 1'b1;
                        s_raddr = pos_ff[AW-1:0];
                     end
                  end
               endcase
            end
         end
         ST_SEED_FIRST: begin
            s_we         = 1'b1;
            s_waddr      = '0;
            s_wdata      = seed_ff;
            p_in         = seed_ff;
            n_in         = AW'(1);
            mreq.start   = 1'b1;
            mreq.operand = fold62(seed_ff);
            mreq.factor  = SEED_MULT;
         end
         ST_SEED_MUL: begin
            if (mrsp.done) begin
               s_we    = 1'b1;
               s_wdata = seed_val;
               p_in    = seed_val;
               if (n_ff == LAST_ADDR) begin
                  // key mixing starts from word 0
                  p_in      = seed_ff;
                  pos_in    = POS_EXHAUSTED;
                  second_in = 1'b0;
                  n_in      = AW'(1);
                  j_in      = 5'd0;
                  k_in      = PASS_ONE;
               end else begin
                  n_in         = n_ff + 1'b1;
                  mreq.start   = 1'b1;
                  mreq.operand = fold62(seed_val);
                  mreq.factor  = SEED_MULT;
               end
            end
         end
         ST_MIX_START: begin
            s_re       = 1'b1;
            key_re     = ~second_ff;
            mreq.start = 1'b1;
         end
         ST_MIX_WAIT: begin
            if (mrsp.done) begin
               s_we = 1'b1;
               p_in = mix_val;
               k_in = k_ff - 1'b1;
               if (!second_ff) begin
                  j_in = j_step;
               end
               if (n_ff == LAST_ADDR) begin
                  n_in = AW'(1);
               end else begin
                  n_in = n_ff + 1'b1;
                  if (k_ff == PW'(1) && !second_ff) begin
                     second_in = 1'b1;
                     k_in      = PASS_TWO;
                  end
               end
            end
         end
         ST_MIX_WRAP: begin
            // word 0 mirrors the last word after each wrap
            s_we    = 1'b1;
            s_waddr = '0;
            s_wdata = p_ff;
            if (k_ff == '0 && !second_ff) begin
               second_in = 1'b1;
               k_in      = PASS_TWO;
            end
         end
         ST_MIX_FINAL: begin
            s_we    = 1'b1;
            s_waddr = '0;
            s_wdata = TOP_BIT;
            pos_in  = POS_EXHAUSTED;
         end
         ST_TW_PRIME: begin
            s_re    = 1'b1;
            s_raddr = '0;
            n_in    = '0;
         end
         ST_TW_A: begin
            if (n_ff == '0) begin
               cur_in = s_rd_ff;
            end
            s_re    = 1'b1;
            s_raddr = next_addr;
         end
         ST_TW_B: begin
            nxt_in  = s_rd_ff;
            s_re    = 1'b1;
            s_raddr = far_addr;
         end
         ST_TW_C: begin
            s_we    = 1'b1;
            s_wdata = twist_val;
            cur_in  = nxt_ff;
            if (n_ff == LAST_ADDR) begin
               s_re    = 1'b1;
               s_raddr = '0;
               pos_in  = '0;
            end else begin
               n_in = n_ff + 1'b1;
            end
         end
         ST_DRAW_OUT: begin
            raw_valid = out_free;
            if (out_free) begin
               pos_in = pos_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         plan_ff   <= PLAN_NONE;
         second_ff <= 1'b0;
         pos_ff    <= POS_UNSEEDED;
      end else begin
         state_ff  <= state_in;
         plan_ff   <= plan_in;
         second_ff <= second_in;
         pos_ff    <= pos_in;
      end
      k_ff    <= k_in;
      n_ff    <= n_in;
      j_ff    <= j_in;
      len_ff  <= len_in;
      p_ff    <= p_in;
      cur_ff  <= cur_in;
      nxt_ff  <= nxt_in;
      seed_ff <= seed_in;
   end

   always_ff @(posedge clock) begin
      if (s_we) begin
         state_mem[s_waddr] <= s_wdata;
      end
      if (s_re) begin
         s_rd_ff <= state_mem[s_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[key_waddr] <= cmd.data_word;
      end
      if (key_re) begin
         key_rd_ff <= key_mem[key_raddr];
      end
   end

   assign raw_word = s_rd_ff;

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_UNSEEDED)
      else $error("read position out of range");

   a_draw_seeded: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DRAW_OUT |-> pos_ff < POS_EXHAUSTED)
      else $error("draw from exhausted or unseeded state");

   a_pos_advance: assert property (@(posedge clock) disable iff (reset)
      raw_valid |=> pos_ff == $past(pos_ff) + 1'b1)
      else $error("read position did not advance after a draw");

   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      !(s_we && s_re && s_waddr == s_raddr))
      else $error("state memory read and write hit the same word");

endmodule

>>> hdl/mersenne_twister_64_prng.sv
// Draw: the state word is read into a register, then the tempered result beat is registered at the output;
// a full output holds the draw, and no new command is accepted until the draw has left. A draw that finds
// the state used up first regenerates it.
// The first draw without a prior seed also seeds from 5489.
// Synchronous active-high reset marks the generator unseeded; memories are not cleared.
module mersenne_twister_64_prng
   import mt64_pkg::*;
#(
   parameter int STATE_DEPTH  = STATE_DEPTH_DEF,
   parameter int TWIST_OFFSET = TWIST_OFFSET_DEF,
   parameter int KEY_DEPTH    = KEY_DEPTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [79:0]  req_tdata,   // data_word[63:0], key_slot[67:64], key_count[72:68]
   input  logic [1:0]   req_tuser,   // operation[1:0]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata    // random_value[63:0], raw_word[127:64]
);

   cmd_type     cmd;
   logic        out_free, raw_valid;
   logic [63:0] raw_word;

   logic         rsp_valid_ff, rsp_valid_in;
   logic [127:0] rsp_data_ff, rsp_data_in;

   assign cmd.operation = req_tuser;
   assign cmd.data_word = req_tdata[63:0];
   assign cmd.key_slot  = req_tdata[67:64];
   assign cmd.key_count = req_tdata[72:68];

   mt64_engine #(
      .STATE_DEPTH  (STATE_DEPTH),
      .TWIST_OFFSET (TWIST_OFFSET),
      .KEY_DEPTH    (KEY_DEPTH)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .cmd_valid (req_tvalid),
      .cmd_ready (req_tready),
      .out_free  (out_free),
      .raw_valid (raw_valid),
      .raw_word  (raw_word)
   );

   assign out_free = ~rsp_valid_ff | rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (raw_valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {raw_word, temper(raw_word)};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> tb/tb_mersenne_twister_64_prng.sv
module tb_mersenne_twister_64_prng
   import mt64_pkg::*;
();

   localparam int NSTATE = 312;
   localparam int NKEY   = 16;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [79:0]  req_tdata;   // data_word[63:0], key_slot[67:64], key_count[72:68]
   logic [1:0]   req_tuser;   // operation[1:0]
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [127:0] rsp_tdata;   // random_value[63:0], raw_word[127:64]

   mersenne_twister_64_prng uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   // generator shadow
   logic [63:0] mt_words [NSTATE];
   logic [63:0] mt_keys [NKEY];
   bit          key_written [NKEY];
   int          mt_pos;
   logic [127:0] draw_queue [$];

   int  mismatches;
   int  cycle_count;
   bit  sender_quiet;
   bit  receiver_quiet;
   localparam int CYCLE_LIMIT = 6000000;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   function automatic logic [63:0] mix62(input logic [63:0] p);
      return p ^ (p >> 62);
   endfunction

   function automatic logic [63:0] shape_output(input logic [63:0] raw);
      logic [63:0] v;
      v = raw;
      v = v ^ ((v >> 29) & 64'h5555_5555_5555_5555);
      v = v ^ ((v << 17) & 64'h71D6_7FFF_EDA6_0000);
      v = v ^ ((v << 37) & 64'hFFF7_EEE0_0000_0000);
      v = v ^ (v >> 43);
      return v;
   endfunction

   task automatic fill_from_word(input logic [63:0] seed);
      mt_words[0] = seed;
      for (int n = 1; n < NSTATE; n++)
         mt_words[n] = SEED_MULT * mix62(mt_words[n-1]) + 64'(n);
      mt_pos = NSTATE;
   endtask

   task automatic fill_from_keys(input int len);
      int i, j;
      i = 1;
      j = 0;
      fill_from_word(KEY_BASE);
      for (int k = (NSTATE > len) ? NSTATE : len; k > 0; k--) begin
         mt_words[i] = (mt_words[i] ^ (mix62(mt_words[i-1]) * MIX_MULT_A)) + mt_keys[j]
                       + 64'(j);
         i++;
         j++;
         if (i >= NSTATE) begin
            mt_words[0] = mt_words[NSTATE-1];
            i = 1;
         end
         if (j >= len) j = 0;
      end
      for (int k = NSTATE - 1; k > 0; k--) begin
         mt_words[i] = (mt_words[i] ^ (mix62(mt_words[i-1]) * MIX_MULT_B)) - 64'(i);
         i++;
         if (i >= NSTATE) begin
            mt_words[0] = mt_words[NSTATE-1];
            i = 1;
         end
      end
      mt_words[0] = TOP_BIT;
      mt_pos = NSTATE;
   endtask

   task automatic regenerate();
      logic [63:0] y;
      for (int n = 0; n < NSTATE; n++) begin
         y = (mt_words[n] & HIGH_MASK) | (mt_words[(n+1) % NSTATE] & LOW_MASK);
         mt_words[n] = mt_words[(n+156) % NSTATE] ^ (y >> 1) ^ (y[0] ? TWIST_MATRIX : 64'd0);
      end
      mt_pos = 0;
   endtask

   task automatic predict_command(input logic [1:0] op, input logic [63:0] data,
                                  input logic [3:0] slot, input logic [4:0] cnt);
      int len;
      logic [63:0] raw;
      case (op)
         OP_SEED_WORD: fill_from_word(data);
         OP_LOAD_KEY: begin
            mt_keys[slot] = data;
            key_written[slot] = 1'b1;
         end
         OP_SEED_KEYS: begin
            len = (cnt == 0) ? 1 : (cnt > NKEY) ? NKEY : cnt;
            fill_from_keys(len);
         end
         default: begin
            if (mt_pos >= NSTATE) begin
               if (mt_pos == NSTATE + 1) fill_from_word(DEFAULT_SEED);
               regenerate();
            end
            raw = mt_words[mt_pos];
            mt_pos++;
            draw_queue.push_back({raw, shape_output(raw)});
         end
      endcase
   endtask

   // send one command beat, predicting on acceptance; valid drops on the next idle cycle
   task automatic send_command(input logic [1:0] op, input logic [63:0] data,
                               input logic [3:0] slot, input logic [4:0] cnt);
      while (!sender_quiet && $urandom_range(99) < 26) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {7'd0, cnt, slot, data};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_command(op, data, slot, cnt);
   endtask

   always @(posedge clock) begin
      if (!reset) rsp_tready <= receiver_quiet || ($urandom_range(99) >= 26);
   end

   always @(posedge clock) begin
      logic [127:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (draw_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected draw beat %h", rsp_tdata);
         end else begin
            want = draw_queue.pop_front();
            if (want[63:0] !== rsp_tdata[63:0] || want[127:64] !== rsp_tdata[127:64]) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("draw mismatch: random exp %h got %h, raw exp %h got %h",
                           want[63:0], rsp_tdata[63:0], want[127:64], rsp_tdata[127:64]);
            end
         end
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // draws a count from 1 up to the run of keys written from slot 0, at least 1
   function automatic logic [4:0] usable_count();
      int n;
      n = 0;
      while (n < NKEY && key_written[n]) n++;
      return 5'($urandom_range(n < 1 ? 1 : n, 1));
   endfunction

   task automatic drain();
      req_tvalid <= 1'b0;
      while (draw_queue.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic test_default_seed();
      // first draws with no seed fall back to the default word
      repeat (3) send_command(OP_DRAW, rand64(), 4'($urandom), 5'($urandom));
   endtask

   task automatic test_word_seeds();
      send_command(OP_SEED_WORD, 64'd0, 4'd0, 5'd0);
      repeat (2) send_command(OP_DRAW, 64'd0, 4'd0, 5'd0);
      send_command(OP_SEED_WORD, {64{1'b1}}, 4'hF, 5'h1F);
      repeat (2) send_command(OP_DRAW, {64{1'b1}}, 4'hF, 5'h1F);
   endtask

   task automatic test_key_seeds();
      for (int s = 0; s < NKEY; s++)
         send_command(OP_LOAD_KEY, (s[0] ? {64{1'b1}} : rand64()), 4'(s), 5'($urandom));
      send_command(OP_SEED_KEYS, 64'd0, 4'd0, 5'd0);    // zero count acts as one
      send_command(OP_DRAW, 64'd0, 4'd0, 5'd0);
      send_command(OP_SEED_KEYS, 64'd0, 4'd0, 5'd31);   // saturates to full depth
      send_command(OP_DRAW, 64'd0, 4'd0, 5'd0);
      send_command(OP_SEED_KEYS, 64'd0, 4'd0, 5'd16);
      send_command(OP_DRAW, 64'd0, 4'd0, 5'd0);
   endtask

   task automatic test_wraparound();
      // walk past the end of the state
      sender_quiet = 1'b1;
      receiver_quiet = 1'b1;
      repeat (320) send_command(OP_DRAW, rand64(), 4'($urandom), 5'($urandom));
      sender_quiet = 1'b0;
      receiver_quiet = 1'b0;
   endtask

   task automatic test_random_mix();
      int pick;
      logic [4:0] cnt;
      for (int n = 0; n < 50; n++) begin
         pick = $urandom_range(99);
         if (pick < 80)
            send_command(OP_DRAW, rand64(), 4'($urandom), 5'($urandom));
         else if (pick < 90)
            send_command(OP_LOAD_KEY, rand64(), 4'($urandom), 5'($urandom));
         else if (pick < 96)
            send_command(OP_SEED_WORD, rand64(), 4'($urandom), 5'($urandom));
         else begin
            cnt = usable_count();
            if ($urandom_range(3) == 0 && key_written[NKEY-1]) cnt = 5'($urandom_range(31, 16));
            send_command(OP_SEED_KEYS, rand64(), 4'($urandom), cnt);
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = OP_DRAW;
      rsp_tready = 1'b0;
      mismatches = 0;
      cycle_count = 0;
      sender_quiet = 1'b0;
      receiver_quiet = 1'b0;
      mt_pos = NSTATE + 1;
      for (int s = 0; s < NKEY; s++) begin
         mt_keys[s] = '0;
         key_written[s] = 1'b0;
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_seed();
      test_word_seeds();
      test_key_seeds();
      test_wraparound();
      test_random_mix();
      drain();
      if (mismatches == 0 && draw_queue.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

>>> sim.f
hdl/mt64_pkg.sv
hdl/mt64_mul.sv
hdl/mt64_engine.sv
hdl/mersenne_twister_64_prng.sv
tb/tb_mersenne_twister_64_prng.sv
